// File: hdl/i2cms_pkg.sv
// shared types and constants for the i2c master bit sequencer
package i2cms_pkg;

    localparam int unsigned BitsPerByte  = 8;
    localparam int unsigned PhaseWidth   = 5;
    localparam int unsigned ByteTicks    = 19;
    localparam int unsigned InDataWidth  = 16;
    localparam int unsigned OutDataWidth = 16;

    localparam logic [PhaseWidth-1:0] DataPhases = PhaseWidth'(2 * BitsPerByte);
    localparam logic [PhaseWidth-1:0] AckHigh    = PhaseWidth'(2 * BitsPerByte + 1);
    localparam logic [PhaseWidth-1:0] LastPhase  = PhaseWidth'(ByteTicks - 1);

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        cmd_t                  cmd;
        logic [7:0]            tx_shift;
        logic [7:0]            rx_shift;
        logic                  ack_latch;
        logic                  nack_wanted;
        logic                  scl_drive;
        logic                  sda_drive;
    } seq_state_t;

    // packed from the highest bit down, so req_type lands in the lowest bits
    typedef struct packed {
        logic       sda_in;
        logic       send_nack;
        logic [7:0] tx_byte;
        logic [2:0] req_type;
    } tick_in_t;

    typedef struct packed {
        logic busy_res;
        logic done_res;
    } tick_flags_t;

endpackage

// File: hdl/i2c_master_bit_sequencer_core.sv
// top level of the i2c master bit sequencer: stream ports and result register
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: req_type, tx_byte, send_nack, sda_in
//  m_      | out | m_tvalid/m_tready  | m_tdata: scl, sda, busy, done, rx_byte, ack
//
// one tick per cycle unless m_tready low holds a waiting result; each tick accepted
// gives its result next cycle from the result register, the only pipeline stage
// s_tready stays high while the result register is empty or being drained
// reset returns the sequencer to idle with both lines released
module i2c_master_bit_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // req_type[2:0], tx_byte[10:3], send_nack[11], sda_in[12], zero[15:13]
    input  logic [i2cms_pkg::InDataWidth-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_received[12], zero[15:13]
    output logic [i2cms_pkg::OutDataWidth-1:0]  m_tdata
);
    import i2cms_pkg::*;

    seq_state_t  state_reg;
    seq_state_t  state_next;
    tick_in_t    tick_in;
    tick_flags_t flags;
    logic        out_valid_reg;
    logic [OutDataWidth-1:0] out_data_reg;
    logic        accept;

    assign tick_in = tick_in_t'(s_tdata[12:0]);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    i2cms_step u_step (
        .cur_state(state_reg),
        .tick_in  (tick_in),
        .nxt_state(state_next),
        .flags    (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: '0, cmd: CMD_IDLE, tx_shift: '0, rx_shift: '0,
                           ack_latch: 1'b0, nack_wanted: 1'b0,
                           scl_drive: 1'b1, sda_drive: 1'b1};
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {3'b000, state_next.ack_latch, state_next.rx_shift,
                             flags.done_res, flags.busy_res,
                             state_next.sda_drive, state_next.scl_drive};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hdl/i2cms_step.sv
// next-state logic for one bus phase tick of the sequencer
module i2cms_step (
    input  i2cms_pkg::seq_state_t  cur_state,
    input  i2cms_pkg::tick_in_t    tick_in,
    output i2cms_pkg::seq_state_t  nxt_state,
    output i2cms_pkg::tick_flags_t flags
);
    import i2cms_pkg::*;

    always_comb begin
        seq_state_t s;
        logic [PhaseWidth-1:0] p;
        logic last;
        s = cur_state;
        last = 1'b0;
        flags = '0;

        if (s.cmd == CMD_IDLE) begin
            case (tick_in.req_type)
                CMD_START, CMD_STOP: begin
                    s.cmd = cmd_t'(tick_in.req_type);
                    s.phase = '0;
                end
                CMD_WRITE: begin
                    s.cmd = CMD_WRITE;
                    s.phase = '0;
                    s.tx_shift = tick_in.tx_byte;
                end
                CMD_READ: begin
                    s.cmd = CMD_READ;
                    s.phase = '0;
                    s.nack_wanted = tick_in.send_nack;
                end
                default: begin
                end
            endcase
        end

        p = s.phase;
        case (s.cmd)
            CMD_START: begin
                s.scl_drive = (p < PhaseWidth'(2));
                s.sda_drive = (p == '0) || (p == PhaseWidth'(3));
                last = (p >= PhaseWidth'(3));
            end
            CMD_STOP: begin
                s.scl_drive = (p >= PhaseWidth'(1));
                s.sda_drive = (p >= PhaseWidth'(2));
                last = (p >= PhaseWidth'(2));
            end
            CMD_WRITE: begin
                if (p < DataPhases) begin
                    s.sda_drive = s.tx_shift[7];
                    s.scl_drive = p[0];
                    if (p[0]) begin
                        s.tx_shift = {s.tx_shift[6:0], 1'b0};
                    end
                end else begin
                    s.sda_drive = 1'b1;
                    s.scl_drive = (p == AckHigh);
                    if (p == AckHigh) begin
                        s.ack_latch = tick_in.sda_in;
                    end
                end
                last = (p >= LastPhase);
            end
            CMD_READ: begin
                if (p < DataPhases) begin
                    s.sda_drive = 1'b1;
                    s.scl_drive = p[0];
                    if (p[0]) begin
                        s.rx_shift = {s.rx_shift[6:0], tick_in.sda_in};
                    end
                end else begin
                    s.sda_drive = s.nack_wanted;
                    s.scl_drive = (p == AckHigh);
                end
                last = (p >= LastPhase);
            end
            default: begin
            end
        endcase

        if (s.cmd != CMD_IDLE) begin
            if (last) begin
                flags.done_res = 1'b1;
                s.cmd = CMD_IDLE;
                s.phase = '0;
            end else begin
                flags.busy_res = 1'b1;
                s.phase = p + PhaseWidth'(1);
            end
        end

        nxt_state = s;
    end

endmodule
